// ----- hw/rtl/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, constants and helpers for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_N       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);

  localparam logic [7:0] GLOB_STAR = 8'h2A;
  localparam logic [7:0] GLOB_ANY  = 8'h3F;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FEED   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // classified item handed from front to back
  typedef struct packed {
    mode_t      op;
    logic [7:0] chr;
    logic       is_star;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_rd_t;

  function automatic logic [7:0] fold_char(logic [7:0] c, logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/wgm_ifs.sv -----
// ----------------------------------------------------------------------------
// wgm channel interfaces
// Valid/ready channels for items, results and the configuration register.
// ----------------------------------------------------------------------------
interface wgm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  modport source (output valid, mode, char_code, input ready);
  modport sink   (input valid, mode, char_code, output ready);
endinterface

interface wgm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

interface wgm_cfg_if;
  logic valid;
  logic ready;
  logic ignore_case;
  modport source (output valid, ignore_case, input ready);
  modport sink   (input valid, ignore_case, output ready);
endinterface

// ----- hw/rtl/wgm_front.sv -----
// ----------------------------------------------------------------------------
// wgm_front
// Accepts items, decodes the mode and folds subject characters.
// ----------------------------------------------------------------------------
module wgm_front
  import wgm_pkg::*;
(
  input  logic         ignore_case,
  input  logic         q_full,
  wgm_cmd_if.sink      cmd,
  output q_wr_t        q_wr
);

  mode_t op;

  assign op        = mode_t'(cmd.mode);
  assign cmd.ready = !q_full;

  always_comb begin
    q_wr.push        = cmd.valid && !q_full;
    q_wr.cmd.op      = op;
    q_wr.cmd.is_star = (cmd.char_code == GLOB_STAR);
    unique case (op)
      // subject bytes are folded once here, pattern bytes at compare time
      MODE_FEED:   q_wr.cmd.chr = fold_char(cmd.char_code, ignore_case);
      MODE_APPEND: q_wr.cmd.chr = cmd.char_code;
      default:     q_wr.cmd.chr = '0;
    endcase
  end

endmodule

// ----- hw/rtl/wgm_queue.sv -----
// ----------------------------------------------------------------------------
// wgm_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module wgm_queue
  import wgm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t q_rd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign q_rd.avail = (count != 2'd0);
  assign q_rd.cmd   = slots[rd_ptr];
  assign do_pop     = pop && q_rd.avail;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({q_wr.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/wgm_back.sv -----
// ----------------------------------------------------------------------------
// wgm_back
// Pattern store, active-position set update and the result register.
// ----------------------------------------------------------------------------
module wgm_back
  import wgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         ignore_case,
  input  q_rd_t        q_rd,
  output logic         pop,
  wgm_res_if.source    res
);

  logic [7:0]             pat [PATTERN_MAX];
  logic [LEN_W-1:0]       len;
  logic [PATTERN_MAX-1:0] lmask;
  logic [POS_N-1:0]       rvec;
  logic [POS_N-1:0]       rvec_next;
  logic [POS_N-1:0]       act;
  logic                   ovf;
  logic                   out_valid;
  logic                   out_matched;
  logic                   out_ovf;

  logic [POS_N-1:0]       star_m;
  logic [POS_N-1:0]       stay;
  logic [POS_N-1:0]       adv;
  logic [POS_N-1:0]       nxt_raw;
  logic [POS_N:0]         sum_x;
  logic [POS_N:0]         sum_y;
  logic [POS_N:0]         sum_s;
  logic [POS_N:0]         carry;
  logic [POS_N-1:0]       act_next;
  logic                   slot_free;
  logic                   has_room;
  logic [IDX_W-1:0]       wr_idx;

  assign slot_free = !out_valid || res.ready;
  assign pop       = q_rd.avail && ((q_rd.cmd.op != MODE_END) || slot_free);
  assign has_room  = (len < LEN_W'(PATTERN_MAX));
  assign wr_idx    = len[IDX_W-1:0];

  // one lane per pattern position
  always_comb begin
    star_m = '0;
    adv    = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star_m[i] = lmask[i] && (pat[i] == GLOB_STAR);
      adv[i+1]  = lmask[i] && act[i] && (pat[i] != GLOB_STAR) &&
                  ((pat[i] == GLOB_ANY) ||
                   (fold_char(pat[i], ignore_case) == q_rd.cmd.chr));
    end
    stay    = act & star_m;
    nxt_raw = stay | adv;
  end

  // star closure as a carry chain: a run of stars passes activity upward
  assign sum_x    = {1'b0, star_m};
  assign sum_y    = {1'b0, nxt_raw & star_m};
  assign sum_s    = sum_x + sum_y;
  assign carry    = sum_s ^ sum_x ^ sum_y;
  assign act_next = nxt_raw | carry[POS_N-1:0];

  // closure of the start position, extended as the pattern grows
  always_comb begin
    rvec_next = rvec;
    rvec_next[len + LEN_W'(1)] = rvec[len] && q_rd.cmd.is_star;
  end

  always_ff @(posedge clk) begin
    if (pop && q_rd.cmd.op == MODE_APPEND && has_room) begin
      pat[wr_idx] <= q_rd.cmd.chr;
    end
    if (pop && q_rd.cmd.op == MODE_END) begin
      out_matched <= act[len] && !ovf;
      out_ovf     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      lmask     <= '0;
      rvec      <= POS_N'(1);
      act       <= POS_N'(1);
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        unique case (q_rd.cmd.op)
          MODE_CLEAR: begin
            len   <= '0;
            lmask <= '0;
            rvec  <= POS_N'(1);
            act   <= POS_N'(1);
            ovf   <= 1'b0;
          end
          MODE_APPEND: begin
            if (has_room) begin
              len           <= len + LEN_W'(1);
              lmask[wr_idx] <= 1'b1;
              rvec          <= rvec_next;
              act           <= rvec_next;
            end else begin
              ovf <= 1'b1;
              act <= rvec;
            end
          end
          MODE_FEED: begin
            act <= act_next;
          end
          MODE_END: begin
            act <= rvec;
          end
          default: begin
            act <= act;
          end
        endcase
      end
      if (pop && q_rd.cmd.op == MODE_END) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid            = out_valid;
  assign res.matched          = out_matched;
  assign res.pattern_overflow = out_ovf;

endmodule

// ----- hw/rtl/wildcard_glob_match.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_match
// Streams subjects against a stored glob pattern with '*' and '?'.
// ----------------------------------------------------------------------------
//  channel  role    payload                      note
//  cmd      sink    mode, char_code              one item per accept
//  cfg      sink    ignore_case                  always ready
//  res      source  matched, pattern_overflow    one result per end item
//
// one item per cycle sustained while results are taken; the position-set
// update with its star closure carry chain runs once per subject byte in
// the back part. an accepted end item is held in the queue, then its
// result is registered once the result register is free.
// the pattern store has no clearing pass.
// an end item waits in the queue while the result register holds an
// untaken result; cmd.ready drops only when the two-entry queue is full.
module wildcard_glob_match
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  wgm_cmd_if.sink    cmd,
  wgm_cfg_if.sink    cfg,
  wgm_res_if.source  res
);

  logic  ignore_case;
  logic  q_full;
  logic  pop;
  q_wr_t q_wr;
  q_rd_t q_rd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b0;
    end else if (cfg.valid) begin
      ignore_case <= cfg.ignore_case;
    end
  end

  wgm_front u_front (
    .ignore_case (ignore_case),
    .q_full      (q_full),
    .cmd         (cmd),
    .q_wr        (q_wr)
  );

  wgm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  wgm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ignore_case (ignore_case),
    .q_rd        (q_rd),
    .pop         (pop),
    .res         (res)
  );

endmodule

// ----- hw/rtl/wgm_checker.sv -----
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks for the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wgm_checker (
  input logic clk,
  input logic rst,
  input logic cmd_ready,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_matched,
  input logic res_pattern_overflow
);

  // a waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_matched) &&
                                $stable(res_pattern_overflow))
    else $error("result changed while stalled");

  // overflow forces no match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_matched && res_pattern_overflow))
    else $error("match reported with pattern overflow");

  a_rst_res: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // queue is empty after reset
  a_rst_ready: assert property (@(posedge clk)
    rst |=> cmd_ready)
    else $error("item channel not ready after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind wildcard_glob_match wgm_checker u_wgm_checker (
  .clk                  (clk),
  .rst                  (rst),
  .cmd_ready            (cmd.ready),
  .cfg_valid            (cfg.valid),
  .cfg_ready            (cfg.ready),
  .res_valid            (res.valid),
  .res_ready            (res.ready),
  .res_matched          (res.matched),
  .res_pattern_overflow (res.pattern_overflow)
);

// ----- verif/tb_wildcard_glob_match.sv -----
// ----------------------------------------------------------------------------
// tb_wildcard_glob_match
// Self-checking bench for the glob matcher. Patterns with stars, question
// marks and plain bytes are loaded, subjects are streamed against them and
// every end-of-subject result is compared with a cycle-free position-set
// predictor. Both channels idle in random bursts, and the case-folding
// register is changed between phases, sometimes in the middle of a subject.
// ----------------------------------------------------------------------------
module tb_wildcard_glob_match;
  import wgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } verdict_t;

  typedef struct {
    mode_t      op;
    logic [7:0] chr;
  } glob_item_t;

  class glob_scoreboard;
    logic [7:0]     pat_bytes [PATTERN_MAX];
    int unsigned    pat_len;
    bit [POS_N-1:0] live;
    bit             overflowed;
    bit             fold_on;
    verdict_t       verdicts_due [$];
    int unsigned    mismatches;
    int unsigned    reports;
    int unsigned    results_seen;
    int unsigned    hits_seen;
    int unsigned    overflow_seen;

    function new();
      pat_len    = 0;
      overflowed = 1'b0;
      fold_on    = 1'b0;
      live       = '0;
      live[0]    = 1'b1;
    endfunction

    function void set_ignore_case(bit v);
      fold_on = v;
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      if (fold_on && c >= LOWER_A && c <= LOWER_Z) begin
        return c - CASE_GAP;
      end
      return c;
    endfunction

    // a live star also makes the position after it live, chaining through runs
    function bit [POS_N-1:0] spread_stars(bit [POS_N-1:0] s);
      for (int i = 0; i < pat_len; i++) begin
        if (s[i] && pat_bytes[i] == GLOB_STAR) begin
          s[i+1] = 1'b1;
        end
      end
      return s;
    endfunction

    function void note_item(mode_t op, logic [7:0] c);
      bit [POS_N-1:0] cur;
      bit [POS_N-1:0] nxt;
      verdict_t       v;
      case (op)
        MODE_CLEAR: begin
          pat_len    = 0;
          overflowed = 1'b0;
          live       = '0;
          live[0]    = 1'b1;
        end
        MODE_APPEND: begin
          if (pat_len < PATTERN_MAX) begin
            pat_bytes[pat_len] = c;
            pat_len++;
          end else begin
            overflowed = 1'b1;
          end
          live    = '0;
          live[0] = 1'b1;
        end
        MODE_FEED: begin
          cur = spread_stars(live);
          nxt = '0;
          for (int i = 0; i < pat_len; i++) begin
            if (cur[i]) begin
              if (pat_bytes[i] == GLOB_STAR) begin
                nxt[i] = 1'b1;
              end else if (pat_bytes[i] == GLOB_ANY || upcase(pat_bytes[i]) == upcase(c)) begin
                nxt[i+1] = 1'b1;
              end
            end
          end
          live = spread_stars(nxt);
        end
        default: begin
          cur = spread_stars(live);
          v.matched          = cur[pat_len] && !overflowed;
          v.pattern_overflow = overflowed;
          verdicts_due.push_back(v);
          live    = '0;
          live[0] = 1'b1;
        end
      endcase
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (reports < 10) begin
        reports++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
      end
    endfunction

    function void check_result(logic got_match, logic got_ovf);
      verdict_t want;
      results_seen++;
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result matched=%0b overflow=%0b",
                                got_match, got_ovf));
        return;
      end
      want = verdicts_due.pop_front();
      if (got_match !== want.matched) begin
        flag_mismatch($sformatf("matched expected %0b actual %0b", want.matched, got_match));
      end
      if (got_ovf !== want.pattern_overflow) begin
        flag_mismatch($sformatf("pattern_overflow expected %0b actual %0b",
                                want.pattern_overflow, got_ovf));
      end
      hits_seen     += want.matched;
      overflow_seen += want.pattern_overflow;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  wgm_cmd_if cmd_ch ();
  wgm_cfg_if cfg_ch ();
  wgm_res_if res_ch ();

  wildcard_glob_match u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  glob_scoreboard sb;
  glob_item_t     item_buf [$];
  bit             idle_on = 1'b1;
  int unsigned    items_sent;
  int unsigned    cfg_writes;
  int unsigned    cycle_count;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, sb.verdicts_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: take results and stall in random bursts
  initial begin
    int unsigned stall;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        sb.check_result(res_ch.matched, res_ch.pattern_overflow);
      end
      if (stall > 0) begin
        stall--;
        res_ch.ready <= (stall == 0);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(mode_t op, logic [7:0] c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= op;
    cmd_ch.char_code <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_item(op, c);
    items_sent++;
  endtask

  task automatic write_ignore_case(bit v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.ignore_case <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_ignore_case(v);
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // no results outstanding, then let items that give none drain through
  task automatic settle_block();
    cmd_ch.valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0:       c = "a";
      1:       c = "A";
      2:       c = "b";
      3:       c = "B";
      default: c = 8'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_pat_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return GLOB_STAR;
    end else if (r < 5) begin
      return GLOB_ANY;
    end
    return pick_text_char();
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'h20;
    end else if (c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic void push_item(mode_t op, logic [7:0] c);
    glob_item_t it;
    it.op  = op;
    it.chr = c;
    item_buf.push_back(it);
  endfunction

  // one pattern load followed by a few subjects, or a short burst of noise
  function automatic void queue_glob_sequence();
    logic [7:0]  pat  [$];
    logic [7:0]  subj [$];
    logic [7:0]  c;
    int unsigned r;
    int unsigned plen;
    mode_t       op;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) begin
        op = mode_t'($urandom_range(0, 3));
        if (op == MODE_APPEND || op == MODE_FEED) begin
          push_item(op, 8'($urandom_range(1, 255)));
        end else begin
          push_item(op, 8'($urandom_range(0, 255)));
        end
      end
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 80) begin
      plen = $urandom_range(0, 8);
    end else if (r < 95) begin
      plen = $urandom_range(9, PATTERN_MAX);
    end else begin
      plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
    end
    push_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    repeat (plen) begin
      c = pick_pat_char();
      pat.push_back(c);
      push_item(MODE_APPEND, c);
    end
    repeat ($urandom_range(1, 4)) begin
      subj.delete();
      if ($urandom_range(0, 9) < 6) begin
        // subject built to fit the pattern, then sometimes spoiled
        for (int i = 0; i < pat.size() && i < PATTERN_MAX; i++) begin
          if (pat[i] == GLOB_STAR) begin
            repeat ($urandom_range(0, 3)) subj.push_back(pick_text_char());
          end else if (pat[i] == GLOB_ANY) begin
            subj.push_back(pick_text_char());
          end else if ($urandom_range(0, 3) == 0) begin
            subj.push_back(flip_case(pat[i]));
          end else begin
            subj.push_back(pat[i]);
          end
        end
        if ($urandom_range(0, 4) == 0 && subj.size() > 0) begin
          subj[$urandom_range(0, subj.size() - 1)] = pick_text_char();
        end
      end else begin
        repeat ($urandom_range(0, 10)) subj.push_back(pick_text_char());
      end
      foreach (subj[i]) begin
        if ($urandom_range(0, 39) == 0) begin
          push_item(MODE_APPEND, pick_pat_char());
        end
        push_item(MODE_FEED, subj[i]);
      end
      push_item(MODE_END, 8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    glob_item_t  it;
    int unsigned sent;
    sb = new();
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.mode        <= MODE_CLEAR;
    cmd_ch.char_code   <= 8'h00;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.ignore_case <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_ignore_case(1'b0);

    // empty pattern against empty and non-empty subjects
    send_item(MODE_END, 8'h00);
    send_item(MODE_FEED, 8'hFF);
    send_item(MODE_END, 8'hFF);
    // pattern a*? followed by byte zero
    send_item(MODE_APPEND, "a");
    send_item(MODE_APPEND, GLOB_STAR);
    send_item(MODE_APPEND, GLOB_ANY);
    send_item(MODE_APPEND, 8'h00);
    send_item(MODE_FEED, "a");
    send_item(MODE_FEED, "x");
    send_item(MODE_FEED, "y");
    send_item(MODE_FEED, 8'h00);
    send_item(MODE_END, 8'h00);
    // wrong case without folding
    send_item(MODE_FEED, "A");
    send_item(MODE_FEED, "z");
    send_item(MODE_FEED, 8'h00);
    send_item(MODE_END, 8'h55);
    // append in the middle of a subject restarts it
    send_item(MODE_FEED, "a");
    send_item(MODE_APPEND, 8'h80);
    send_item(MODE_FEED, "a");
    send_item(MODE_FEED, "q");
    send_item(MODE_FEED, 8'h00);
    send_item(MODE_FEED, 8'h80);
    send_item(MODE_END, 8'hAA);
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_END, 8'h00);

    // random traffic; the item buffer carries over so some writes land mid-subject
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      if (ph < 2) begin
        write_ignore_case(ph == 0);
      end else begin
        write_ignore_case(1'($urandom_range(0, 1)));
      end
      idle_on = (ph != PHASES - 1);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (item_buf.size() == 0) begin
          queue_glob_sequence();
        end
        it = item_buf.pop_front();
        send_item(it.op, it.chr);
        sent++;
      end
    end

    settle_block();
    $display("%0d items over %0d register writes, both folding settings, idle and back-to-back",
             items_sent, cfg_writes);
    $display("%0d results: %0d matched, %0d with overflow, %0d mismatches",
             sb.results_seen, sb.hits_seen, sb.overflow_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
